// File: sv/sorted_insert_ring_queue_assert.svh
// Assertion macros for the sorted insert ring queue.
`ifndef SORTED_INSERT_RING_QUEUE_ASSERT_SVH
`define SORTED_INSERT_RING_QUEUE_ASSERT_SVH

// Same-cycle implication, clocked on i_clk, off during reset.
`define SRQ_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk, off during reset.
`define SRQ_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/srq_pkg.sv
`default_nettype none

package srq_pkg;

    localparam int CAPACITY = 16;
    localparam int PTR_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int HANDLE_W = 8;
    localparam int KEY_W    = 16;
    localparam int OCC_W    = 5;

    typedef enum logic [1:0] {
        ACT_APPEND = 2'd0,
        ACT_SORTED = 2'd1,
        ACT_REMOVE = 2'd2,
        ACT_NOP    = 2'd3
    } t_action;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [KEY_W-1:0]    key;
    } t_entry;

    typedef struct packed {
        logic                accepted;
        logic                out_valid;
        logic [HANDLE_W-1:0] out_handle;
        logic [KEY_W-1:0]    out_key;
        logic [OCC_W-1:0]    occupancy;
        logic                is_empty;
        logic                is_full;
    } t_res;

    typedef struct packed {
        logic             we;
        logic [PTR_W-1:0] waddr;
        t_entry           wdata;
        logic             re;
        logic [PTR_W-1:0] raddr;
    } t_ram_req;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(CAPACITY - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
        return (p == '0) ? PTR_W'(CAPACITY - 1) : p - PTR_W'(1);
    endfunction

endpackage

`default_nettype wire

// File: sv/srq_ram.sv
`default_nettype none

module srq_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 24
) (
    input  wire logic                                          i_clk,
    input  wire logic                                          i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                              i_wdata,
    input  wire logic                                          i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                              o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: sv/srq_ctrl.sv
`default_nettype none

module srq_ctrl import srq_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire logic [1:0]          i_action,
    input  wire logic [HANDLE_W-1:0] i_handle,
    input  wire logic [KEY_W-1:0]    i_sort_key,
    output t_ram_req                 o_ram,
    input  wire t_entry              i_rdata,
    output logic                     o_res_valid,
    output t_res                     o_res,
    input  wire logic                i_res_ready
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_DEQ   = 4'b0010,
        ST_SHIFT = 4'b0100,
        ST_DONE  = 4'b1000
    } t_state;

    t_state           r_state, n_state;
    logic [PTR_W-1:0] r_head, n_head;
    logic [PTR_W-1:0] r_tail, n_tail;
    logic [CNT_W-1:0] r_count, n_count;
    logic [PTR_W-1:0] r_pos, n_pos;
    logic [CNT_W-1:0] r_left, n_left;
    t_entry           r_entry, n_entry;
    t_res             r_res, n_res;

    logic accept;
    logic full;
    logic empty;

    assign o_ready = (r_state == ST_IDLE);
    assign accept  = i_valid && o_ready;
    assign full    = (r_count == CNT_W'(CAPACITY));
    assign empty   = (r_count == '0);

    always_comb begin
        n_state = r_state;
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        n_pos   = r_pos;
        n_left  = r_left;
        n_entry = r_entry;
        n_res   = r_res;
        o_ram   = '0;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_res   = '0;
                    n_entry = '{handle: i_handle, key: i_sort_key};
                    n_state = ST_DONE;
                    case (i_action)
                        ACT_APPEND: begin
                            if (!full) begin
                                o_ram.we       = 1'b1;
                                o_ram.waddr    = r_tail;
                                o_ram.wdata    = n_entry;
                                n_tail         = ptr_inc(r_tail);
                                n_count        = r_count + CNT_W'(1);
                                n_res.accepted = 1'b1;
                            end
                        end
                        ACT_SORTED: begin
                            if (!full) begin
                                n_tail         = ptr_inc(r_tail);
                                n_count        = r_count + CNT_W'(1);
                                n_res.accepted = 1'b1;
                                if (empty) begin
                                    o_ram.we    = 1'b1;
                                    o_ram.waddr = r_tail;
                                    o_ram.wdata = n_entry;
                                end else begin
                                    o_ram.re    = 1'b1;
                                    o_ram.raddr = ptr_dec(r_tail);
                                    n_pos       = r_tail;
                                    n_left      = r_count;
                                    n_state     = ST_SHIFT;
                                end
                            end
                        end
                        ACT_REMOVE: begin
                            if (!empty) begin
                                o_ram.re        = 1'b1;
                                o_ram.raddr     = r_head;
                                n_head          = ptr_inc(r_head);
                                n_count         = r_count - CNT_W'(1);
                                n_res.accepted  = 1'b1;
                                n_res.out_valid = 1'b1;
                                n_state         = ST_DEQ;
                            end
                        end
                        default: begin
                            n_state = ST_DONE;
                        end
                    endcase
                end
            end
            ST_DEQ: begin
                n_res.out_handle = i_rdata.handle;
                n_res.out_key    = i_rdata.key;
                n_state          = ST_DONE;
            end
            ST_SHIFT: begin
                // i_rdata holds the entry just ahead of r_pos
                if (r_left != '0 && i_rdata.key > r_entry.key) begin
                    o_ram.we    = 1'b1;
                    o_ram.waddr = r_pos;
                    o_ram.wdata = i_rdata;
                    o_ram.re    = 1'b1;
                    o_ram.raddr = ptr_dec(ptr_dec(r_pos));
                    n_pos       = ptr_dec(r_pos);
                    n_left      = r_left - CNT_W'(1);
                end else begin
                    o_ram.we    = 1'b1;
                    o_ram.waddr = r_pos;
                    o_ram.wdata = r_entry;
                    n_state     = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_res_valid     = (r_state == ST_DONE);
        o_res           = r_res;
        o_res.occupancy = OCC_W'(r_count);
        o_res.is_empty  = empty;
        o_res.is_full   = full;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos   <= n_pos;
        r_left  <= n_left;
        r_entry <= n_entry;
        r_res   <= n_res;
    end

endmodule

`default_nettype wire

// File: sv/sorted_insert_ring_queue.sv
// Ring queue of handle/key entries held in one synchronous RAM. Append and
// remove-head act on the tail and head pointers; a sorted insert walks back
// from the tail, moving each entry with a larger key one place on, one entry
// per cycle with a RAM read and write in the same cycle, then drops the new
// entry into the gap. One transfer is worked on at a time: append, refused,
// no-op and sorted-into-empty transfers go straight to their result, while
// remove-head first reads the head entry from the RAM and any other sorted
// insert first moves each entry with a larger key one place on.
// A finished result waits in the output register, so the next transfer can
// be taken while the result is still unread. Full and empty are reported on
// every result; an enqueue on a full queue is refused and a remove on an
// empty queue returns no entry.
`default_nettype none

`include "sorted_insert_ring_queue_assert.svh"

module sorted_insert_ring_queue import srq_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire logic [1:0]          i_action,
    input  wire logic [HANDLE_W-1:0] i_handle,
    input  wire logic [KEY_W-1:0]    i_sort_key,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output logic                     o_accepted,
    output logic                     o_out_valid,
    output logic [HANDLE_W-1:0]      o_out_handle,
    output logic [KEY_W-1:0]         o_out_key,
    output logic [OCC_W-1:0]         o_occupancy,
    output logic                     o_is_empty,
    output logic                     o_is_full
);

    t_ram_req               ram_req;
    logic [$bits(t_entry)-1:0] ram_rdata;
    logic                   res_valid;
    logic                   res_ready;
    t_res                   res;

    logic r_o_valid, n_o_valid;
    t_res r_out;

    srq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_action    (i_action),
        .i_handle    (i_handle),
        .i_sort_key  (i_sort_key),
        .o_ram       (ram_req),
        .i_rdata     (t_entry'(ram_rdata)),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ready (res_ready)
    );

    srq_ram #(
        .DEPTH (CAPACITY),
        .WIDTH ($bits(t_entry))
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_re    (ram_req.re),
        .i_raddr (ram_req.raddr),
        .o_rdata (ram_rdata)
    );

    assign res_ready = !r_o_valid || i_ready;

    always_comb begin
        n_o_valid = r_o_valid;
        if (res_valid && res_ready) begin
            n_o_valid = 1'b1;
        end else if (i_ready) begin
            n_o_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else begin
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign o_valid      = r_o_valid;
    assign o_accepted   = r_out.accepted;
    assign o_out_valid  = r_out.out_valid;
    assign o_out_handle = r_out.out_handle;
    assign o_out_key    = r_out.out_key;
    assign o_occupancy  = r_out.occupancy;
    assign o_is_empty   = r_out.is_empty;
    assign o_is_full    = r_out.is_full;

    `SRQ_ASSERT_NXT(a_one_at_a_time, i_valid && o_ready, !o_ready, "transfer taken while busy")
    `SRQ_ASSERT_IMP(a_deq_accepted, o_valid && o_out_valid, o_accepted, "entry without accept")
    `SRQ_ASSERT_IMP(a_no_entry_zero, o_valid && !o_out_valid, o_out_handle == '0 && o_out_key == '0, "stale entry on result")
    `SRQ_ASSERT_IMP(a_empty_count, o_valid && o_is_empty, o_occupancy == '0 && !o_is_full, "empty with entries")

endmodule

`default_nettype wire

// File: test/testbench.sv
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import srq_pkg::*;

    localparam int IDLE_LIMIT = 4000;
    localparam int HOLD_LEN   = 300;
    localparam int IDLE_PCT   = 28;

    typedef struct {
        t_action             act;
        logic [HANDLE_W-1:0] handle;
        logic [KEY_W-1:0]    key;
    } t_req;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_ready;
    logic [1:0]          i_action;
    logic [HANDLE_W-1:0] i_handle;
    logic [KEY_W-1:0]    i_sort_key;
    logic                o_valid;
    logic                i_ready;
    logic                o_accepted;
    logic                o_out_valid;
    logic [HANDLE_W-1:0] o_out_handle;
    logic [KEY_W-1:0]    o_out_key;
    logic [OCC_W-1:0]    o_occupancy;
    logic                o_is_empty;
    logic                o_is_full;

    t_req        req_q[$];
    t_res        due_status_q[$];
    t_req        next_req;
    t_res        want;

    // shadow copy of the ring
    t_entry      ring[CAPACITY];
    int unsigned ring_head  = 0;
    int unsigned ring_tail  = 0;
    int unsigned ring_count = 0;

    int          n_err     = 0;
    int          n_total   = 0;
    int          n_sent    = 0;
    int          n_taken   = 0;
    int          idle_run  = 0;
    int          hold_left = 0;
    int          hold_mark = 150;
    bit          in_xfer   = 1'b0;

    sorted_insert_ring_queue dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_action     (i_action),
        .i_handle     (i_handle),
        .i_sort_key   (i_sort_key),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_accepted   (o_accepted),
        .o_out_valid  (o_out_valid),
        .o_out_handle (o_out_handle),
        .o_out_key    (o_out_key),
        .o_occupancy  (o_occupancy),
        .o_is_empty   (o_is_empty),
        .o_is_full    (o_is_full)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic t_res ring_step(t_action act, logic [HANDLE_W-1:0] h,
                                       logic [KEY_W-1:0] k);
        t_res        r;
        int unsigned pos;
        int unsigned prev;
        int unsigned left;
        r = '0;
        case (act)
            ACT_APPEND, ACT_SORTED: begin
                if (ring_count < CAPACITY) begin
                    pos  = ring_tail;
                    left = ring_count;
                    if (act == ACT_SORTED) begin
                        while (left > 0 && ring[(pos + CAPACITY - 1) % CAPACITY].key > k) begin
                            prev      = (pos + CAPACITY - 1) % CAPACITY;
                            ring[pos] = ring[prev];
                            pos       = prev;
                            left--;
                        end
                    end
                    ring[pos]  = {h, k};
                    ring_tail  = (ring_tail + 1) % CAPACITY;
                    ring_count++;
                    r.accepted = 1'b1;
                end
            end
            ACT_REMOVE: begin
                if (ring_count > 0) begin
                    r.out_handle = ring[ring_head].handle;
                    r.out_key    = ring[ring_head].key;
                    r.out_valid  = 1'b1;
                    r.accepted   = 1'b1;
                    ring_head    = (ring_head + 1) % CAPACITY;
                    ring_count--;
                end
            end
            default: ;
        endcase
        r.occupancy = OCC_W'(ring_count);
        r.is_empty  = (ring_count == 0);
        r.is_full   = (ring_count == CAPACITY);
        return r;
    endfunction

    function automatic bit calm_stretch();
        return n_sent >= 450 && n_sent < 700;
    endfunction

    task automatic add_req(t_action act, logic [HANDLE_W-1:0] h, logic [KEY_W-1:0] k);
        t_req r;
        r.act    = act;
        r.handle = h;
        r.key    = k;
        req_q.push_back(r);
        n_total++;
    endtask

    task automatic check_field(string name, int unsigned exp_v, int unsigned got_v);
        if (exp_v != got_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, got_v);
            n_err++;
        end
    endtask

    // sender
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_valid || in_xfer)) begin
            if (req_q.size() != 0 && (calm_stretch() || $urandom_range(99) >= IDLE_PCT)) begin
                next_req = req_q.pop_front();
                i_valid    <= 1'b1;
                i_action   <= next_req.act;
                i_handle   <= next_req.handle;
                i_sort_key <= next_req.key;
                n_sent++;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver, with a long hold-off now and then so the block backs up
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (n_sent >= hold_mark) begin
                hold_left = HOLD_LEN;
                hold_mark += 750;
                i_ready <= 1'b0;
            end else begin
                i_ready <= calm_stretch() || $urandom_range(99) >= IDLE_PCT;
            end
        end
    end

    // monitor and watchdog
    always @(posedge i_clk) begin
        in_xfer = 1'b0;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (due_status_q.size() == 0) begin
                    $error("result transfer with nothing outstanding");
                    n_err++;
                end else begin
                    want = due_status_q.pop_front();
                    check_field("accepted",   want.accepted,   o_accepted);
                    check_field("out_valid",  want.out_valid,  o_out_valid);
                    check_field("out_handle", want.out_handle, o_out_handle);
                    check_field("out_key",    want.out_key,    o_out_key);
                    check_field("occupancy",  want.occupancy,  o_occupancy);
                    check_field("is_empty",   want.is_empty,   o_is_empty);
                    check_field("is_full",    want.is_full,    o_is_full);
                end
            end
            if (i_valid && o_ready) begin
                in_xfer = 1'b1;
                n_taken++;
                due_status_q.push_back(ring_step(t_action'(i_action), i_handle, i_sort_key));
            end
            if ((o_valid && i_ready) || in_xfer)
                idle_run = 0;
            else
                idle_run++;
            if (idle_run >= IDLE_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial begin
        int unsigned mode;
        int unsigned pick;
        int unsigned ksel;
        logic [KEY_W-1:0] k;

        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_ready    = 1'b0;
        i_action   = ACT_NOP;
        i_handle   = '0;
        i_sort_key = '0;

        // directed: empty cases, extremes, ties, fill to full, refusals
        add_req(ACT_REMOVE, 8'h00, 16'h0000);
        add_req(ACT_NOP,    8'hFF, 16'hFFFF);
        add_req(ACT_APPEND, 8'h00, 16'h0000);
        add_req(ACT_APPEND, 8'hFF, 16'hFFFF);
        add_req(ACT_SORTED, 8'h01, 16'h8000);
        add_req(ACT_SORTED, 8'h02, 16'h8000);
        add_req(ACT_SORTED, 8'h03, 16'h0000);
        for (int i = 0; i < 11; i++)
            add_req(ACT_SORTED, 8'($urandom_range(255)),
                    (i % 3 == 0) ? 16'h8000 : 16'($urandom_range(16'hFFFF)));
        add_req(ACT_APPEND, 8'hA5, 16'h1234);
        add_req(ACT_SORTED, 8'h5A, 16'h0000);
        add_req(ACT_NOP,    8'h00, 16'h0000);
        for (int i = 0; i < 4; i++)
            add_req(ACT_REMOVE, 8'($urandom_range(255)), 16'($urandom_range(16'hFFFF)));

        // random: blocks leaning to fill, drain or balance
        for (int b = 0; b < 27; b++) begin
            mode = $urandom_range(2);
            for (int i = 0; i < 50; i++) begin
                pick = $urandom_range(99);
                ksel = $urandom_range(3);
                if (ksel == 0)
                    k = 16'($urandom_range(7));
                else if (ksel == 1)
                    k = $urandom_range(1) ? 16'hFFFF : 16'h0000;
                else
                    k = 16'($urandom_range(16'hFFFF));
                if (pick >= 97)
                    add_req(ACT_NOP, 8'($urandom_range(255)), k);
                else if (pick < ((mode == 0) ? 25 : (mode == 1) ? 70 : 47))
                    add_req(ACT_REMOVE, 8'($urandom_range(255)), k);
                else if ($urandom_range(99) < 65)
                    add_req(ACT_SORTED, 8'($urandom_range(255)), k);
                else
                    add_req(ACT_APPEND, 8'($urandom_range(255)), k);
            end
        end

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (n_taken < n_total || due_status_q.size() != 0)
            @(negedge i_clk);
        repeat (40) @(negedge i_clk);

        if (n_err == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire

// File: sim.f
+incdir+sv
sv/srq_pkg.sv
sv/srq_ram.sv
sv/srq_ctrl.sv
sv/sorted_insert_ring_queue.sv
test/testbench.sv
